// ===== rtl/core/set_color_command_parser_macros.svh =====
// assertion macros for the set color command parser
// used by the top level, no other dependencies
`ifndef SET_COLOR_COMMAND_PARSER_MACROS_SVH
`define SET_COLOR_COMMAND_PARSER_MACROS_SVH
`ifndef ASSERT_OFF
`define SCP_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("scp assertion failed");
`define SCP_ASSERT_NEXT(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("scp assertion failed");
`else
`define SCP_ASSERT(lbl, prop)
`define SCP_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

// ===== rtl/core/scp_pkg.sv =====
// types, codes and constants of the set color command parser
// no dependencies
package scp_pkg;

   localparam int LINE_SIZE = 32;
   localparam int LenW      = $clog2(LINE_SIZE);
   localparam logic [LenW-1:0] LenMax = LenW'(LINE_SIZE - 1);

   localparam int PosW = 4;
   localparam logic [PosW-1:0] PrefixLen = 4'd10;

   localparam logic [7:0] MaxComponent = 8'd255;
   localparam logic [7:0] Separator    = 8'h2c;
   localparam logic [7:0] CharCr       = 8'h0d;
   localparam logic [7:0] CharLf       = 8'h0a;
   localparam logic [7:0] CharSpace    = 8'h20;
   localparam logic [7:0] CharTab      = 8'h09;
   localparam logic [7:0] CharZero     = 8'h30;
   localparam logic [7:0] CharNine     = 8'h39;
   localparam logic [7:0] CharNul      = 8'h00;

   localparam logic [1:0] OP_BYTE     = 2'd0;
   localparam logic [1:0] OP_OVERFLOW = 2'd1;
   localparam logic [1:0] OP_FRAMING  = 2'd2;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_BAD      = 3'd1,
      ST_UNKNOWN  = 3'd2,
      ST_TOO_LONG = 3'd3,
      ST_OVERFLOW = 3'd4,
      ST_FRAMING  = 3'd5
   } status_type;

   typedef enum logic [5:0] {
      PH_PREFIX  = 6'b000001,
      PH_RED     = 6'b000010,
      PH_GREEN   = 6'b000100,
      PH_BLUE    = 6'b001000,
      PH_BAD     = 6'b010000,
      PH_UNKNOWN = 6'b100000
   } phase_type;

   function automatic logic [7:0] prefix_char(input logic [PosW-1:0] pos);
      logic [7:0] ch;
      case (pos)
         4'd0:    ch = 8'h53; // S
         4'd1:    ch = 8'h45; // E
         4'd2:    ch = 8'h54; // T
         4'd3:    ch = 8'h5f; // _
         4'd4:    ch = 8'h43; // C
         4'd5:    ch = 8'h4f; // O
         4'd6:    ch = 8'h4c; // L
         4'd7:    ch = 8'h4f; // O
         4'd8:    ch = 8'h52; // R
         4'd9:    ch = 8'h3d; // =
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

// ===== rtl/core/scp_if.sv =====
// valid/ready channels of the set color command parser
// depends on nothing
interface scp_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] op;
   logic [7:0] rx_byte;

   modport source (output valid, output op, output rx_byte, input ready);
   modport sink (input valid, input op, input rx_byte, output ready);
endinterface

interface scp_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] status;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;

   modport source (output valid, output status, output red, output green, output blue,
                   input ready);
   modport sink (input valid, input status, input red, input green, input blue,
                 output ready);
endinterface

// ===== rtl/core/set_color_command_parser.sv =====
// an item accepted into the input register is parsed from there, and its result is
// loaded into the result register once that register is free, to be taken from then on
// throughput: one item per cycle; only an item that yields a result waits in the input
// register while the result register is stalled
// reset: synchronous, active high; clears both valid flags and the line state
// depends on scp_pkg, scp_if and set_color_command_parser_macros.svh
`include "set_color_command_parser_macros.svh"
module set_color_command_parser
   import scp_pkg::*;
(
   input logic        clock,
   input logic        reset,
   scp_req_if.sink    req_chan,
   scp_rsp_if.source  rsp_chan
);

   logic             in_valid_ff;
   logic [1:0]       op_ff;
   logic [7:0]       byte_ff;

   logic [LenW-1:0]  raw_len_ff, raw_len_in;
   logic [PosW-1:0]  prefix_pos_ff, prefix_pos_in;
   phase_type        phase_ff, phase_in;
   logic [7:0]       acc_ff, acc_in;
   logic             digit_seen_ff, digit_seen_in;
   logic             text_ended_ff, text_ended_in;
   logic [7:0]       held_red_ff, held_red_in;
   logic [7:0]       held_green_ff, held_green_in;

   logic             rsp_valid_ff;
   status_type       status_ff, status_in;
   logic [7:0]       red_ff, red_in;
   logic [7:0]       green_ff, green_in;
   logic [7:0]       blue_ff, blue_in;

   logic             emit;
   logic             restart;
   logic             out_free;
   logic             consume;
   logic             in_ready;
   logic [11:0]      next_value;

   assign out_free   = !rsp_valid_ff || rsp_chan.ready;
   assign consume    = in_valid_ff && (!emit || out_free);
   assign in_ready   = !in_valid_ff || consume;
   assign next_value = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0}
                     + {4'b0000, byte_ff - CharZero};

   always_comb begin
      raw_len_in    = raw_len_ff;
      prefix_pos_in = prefix_pos_ff;
      phase_in      = phase_ff;
      acc_in        = acc_ff;
      digit_seen_in = digit_seen_ff;
      text_ended_in = text_ended_ff;
      held_red_in   = held_red_ff;
      held_green_in = held_green_ff;
      emit          = 1'b0;
      restart       = 1'b0;
      status_in     = ST_OK;
      red_in        = 8'd0;
      green_in      = 8'd0;
      blue_in       = 8'd0;
      if (in_valid_ff) begin
         case (op_ff)
            OP_OVERFLOW: begin
               emit      = 1'b1;
               restart   = 1'b1;
               status_in = ST_OVERFLOW;
            end
            OP_FRAMING: begin
               emit      = 1'b1;
               restart   = 1'b1;
               status_in = ST_FRAMING;
            end
            OP_BYTE: begin
               if (byte_ff == CharCr || byte_ff == CharLf) begin
                  if (raw_len_ff != '0) begin
                     emit    = 1'b1;
                     restart = 1'b1;
                     if (phase_ff == PH_BLUE && digit_seen_ff) begin
                        status_in = ST_OK;
                        red_in    = held_red_ff;
                        green_in  = held_green_ff;
                        blue_in   = acc_ff;
                     end else if (phase_ff == PH_PREFIX || phase_ff == PH_UNKNOWN) begin
                        status_in = ST_UNKNOWN;
                     end else begin
                        status_in = ST_BAD;
                     end
                  end
               end else if (raw_len_ff >= LenMax) begin
                  emit      = 1'b1;
                  restart   = 1'b1;
                  status_in = ST_TOO_LONG;
               end else begin
                  raw_len_in = raw_len_ff + 1'b1;
                  if (!text_ended_ff) begin
                     if (byte_ff == CharNul) begin
                        text_ended_in = 1'b1;
                     end else if (byte_ff != CharSpace && byte_ff != CharTab) begin
                        case (phase_ff)
                           PH_PREFIX: begin
                              if (prefix_pos_ff < PrefixLen &&
                                  byte_ff == prefix_char(prefix_pos_ff)) begin
                                 prefix_pos_in = prefix_pos_ff + 1'b1;
                                 if (prefix_pos_in >= PrefixLen) begin
                                    phase_in = PH_RED;
                                 end
                              end else begin
                                 phase_in = PH_UNKNOWN;
                              end
                           end
                           PH_RED, PH_GREEN, PH_BLUE: begin
                              if (byte_ff inside {[CharZero:CharNine]}) begin
                                 if (next_value > {4'b0000, MaxComponent}) begin
                                    phase_in = PH_BAD;
                                 end else begin
                                    acc_in        = next_value[7:0];
                                    digit_seen_in = 1'b1;
                                 end
                              end else if (byte_ff == Separator && phase_ff != PH_BLUE &&
                                           digit_seen_ff) begin
                                 if (phase_ff == PH_RED) begin
                                    held_red_in = acc_ff;
                                    phase_in    = PH_GREEN;
                                 end else begin
                                    held_green_in = acc_ff;
                                    phase_in      = PH_BLUE;
                                 end
                                 acc_in        = 8'd0;
                                 digit_seen_in = 1'b0;
                              end else begin
                                 phase_in = PH_BAD;
                              end
                           end
                           default: ;
                        endcase
                     end
                  end
               end
            end
            default: ;
         endcase
      end
      if (restart) begin
         raw_len_in    = '0;
         prefix_pos_in = '0;
         phase_in      = PH_PREFIX;
         acc_in        = 8'd0;
         digit_seen_in = 1'b0;
         text_ended_in = 1'b0;
         held_red_in   = 8'd0;
         held_green_in = 8'd0;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_ready) begin
         in_valid_ff <= req_chan.valid;
      end
      if (in_ready && req_chan.valid) begin
         op_ff   <= req_chan.op;
         byte_ff <= req_chan.rx_byte;
      end
   end

   // line state
   always_ff @(posedge clock) begin
      if (reset) begin
         raw_len_ff    <= '0;
         prefix_pos_ff <= '0;
         phase_ff      <= PH_PREFIX;
         acc_ff        <= 8'd0;
         digit_seen_ff <= 1'b0;
         text_ended_ff <= 1'b0;
         held_red_ff   <= 8'd0;
         held_green_ff <= 8'd0;
      end else if (consume) begin
         raw_len_ff    <= raw_len_in;
         prefix_pos_ff <= prefix_pos_in;
         phase_ff      <= phase_in;
         acc_ff        <= acc_in;
         digit_seen_ff <= digit_seen_in;
         text_ended_ff <= text_ended_in;
         held_red_ff   <= held_red_in;
         held_green_ff <= held_green_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= consume && emit;
      end
      if (consume && emit) begin
         status_ff <= status_in;
         red_ff    <= red_in;
         green_ff  <= green_in;
         blue_ff   <= blue_in;
      end
   end

   assign req_chan.ready  = in_ready;
   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.status = status_ff;
   assign rsp_chan.red    = red_ff;
   assign rsp_chan.green  = green_ff;
   assign rsp_chan.blue   = blue_ff;

   `SCP_ASSERT(a_colors_zero_unless_ok, !rsp_valid_ff || status_ff == ST_OK ||
      (red_ff == 8'd0 && green_ff == 8'd0 && blue_ff == 8'd0))
   `SCP_ASSERT(a_prefix_pos_range, prefix_pos_ff <= PrefixLen)
   `SCP_ASSERT(a_raw_len_range, raw_len_ff <= LenMax)
   `SCP_ASSERT_NEXT(a_line_restarts_after_result, consume && emit,
      phase_ff == PH_PREFIX && raw_len_ff == '0 && !digit_seen_ff)

endmodule
